@@ hw/rtl/vsa_pkg.sv @@
`timescale 1ns / 1ps

package vsa_pkg;

  localparam int MAX_INDICES   = 64;
  localparam int HISTORY_DEPTH = 16;
  localparam int SNAP_BITS     = 16;

  localparam int IDX_W  = $clog2(MAX_INDICES);
  localparam int HIST_W = $clog2(HISTORY_DEPTH);
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int ADDR_W = IDX_W + HIST_W;
  localparam int ENT_N  = MAX_INDICES * HISTORY_DEPTH;
  localparam int CFG_W  = 7;
  localparam int VAL_W  = 32;
  localparam int OSN_W  = 16;

  typedef enum logic [1:0] {
    CMD_SET  = 2'd0,
    CMD_SNAP = 2'd1,
    CMD_GET  = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_SAT   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SET_CHK,
    S_SEARCH,
    S_DONE
  } state_e;

  typedef struct packed {
    logic        [SNAP_BITS-1:0] snap;
    logic signed [VAL_W-1:0]     val;
  } entry_t;

endpackage

@@ hw/rtl/versioned_snapshot_array.sv @@
// flow: an accepted beat passes decode and then done; a set to an index with history
// also passes a check state, and a get with history passes the search state, which
// steps the binary search one probe a cycle through the single read port of the entry
// memory; a new beat is taken only in idle, after done has moved the last result out
// reset: snapshot counter 0, length 64, per-index counts cleared at once by valid bits;
// the entry memory is not cleared, so the block is ready right after reset
`timescale 1ns / 1ps

module versioned_snapshot_array (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // index[5:0], value[37:6], snap_query[53:38], zero
  input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // read_value[31:0], snap_number[47:32]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int IW = vsa_pkg::IDX_W;
  localparam int HW = vsa_pkg::HIST_W;
  localparam int CW = vsa_pkg::CNT_W;
  localparam int AW = vsa_pkg::ADDR_W;
  localparam int SW = vsa_pkg::SNAP_BITS;
  localparam int VW = vsa_pkg::VAL_W;
  localparam int LW = vsa_pkg::CFG_W;
  localparam int OW = vsa_pkg::OSN_W;

  vsa_pkg::state_e  state_q, state_d;
  vsa_pkg::cmd_e    cmd_q, cmd_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic signed [VW-1:0] val_q, val_d;
  logic [OW-1:0]    qry_q, qry_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    lo_q, lo_d, hi_q, hi_d;
  logic [HW-1:0]    mid_q, mid_d;
  logic [SW-1:0]    cur_snap_q, cur_snap_d;
  logic [LW-1:0]    cfg_len_q;
  logic signed [VW-1:0] res_val_q, res_val_d;
  logic [OW-1:0]    res_snap_q, res_snap_d;
  vsa_pkg::status_e res_st_q, res_st_d;
  logic             m_valid_q, m_valid_d;
  logic signed [VW-1:0] out_val_q, out_val_d;
  logic [OW-1:0]    out_snap_q, out_snap_d;
  vsa_pkg::status_e out_st_q, out_st_d;

  logic [CW-1:0]    cnt_mem [vsa_pkg::MAX_INDICES];
  logic [vsa_pkg::MAX_INDICES-1:0] cnt_vld_q;
  logic [CW-1:0]    cnt_rdata_q;
  logic             cnt_we;
  logic [CW-1:0]    cnt_wdata;

  vsa_pkg::entry_t  ent_mem [vsa_pkg::ENT_N];
  vsa_pkg::entry_t  ent_rdata_q;
  vsa_pkg::entry_t  ent_wdata;
  logic             ent_we;
  logic [AW-1:0]    ent_waddr, ent_raddr;

  logic             s_acc;
  logic             out_free;
  logic [LW-1:0]    eff_len;
  logic             out_of_range;
  logic [CW-1:0]    cnt_n;
  logic [CW-1:0]    lo_n, hi_n;
  logic [CW:0]      mid_sum;
  logic             snap_le;

  assign s_axis_tready = (state_q == vsa_pkg::S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign eff_len       = (cfg_len_q > LW'(vsa_pkg::MAX_INDICES)) ?
                         LW'(vsa_pkg::MAX_INDICES) : cfg_len_q;
  assign out_of_range  = (LW'(idx_q) >= eff_len);
  assign snap_le       = (OW'(ent_rdata_q.snap) <= qry_q);

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {out_snap_q, out_val_q};
  assign m_axis_tuser  = out_st_q;

  always_ff @(posedge clk_i) begin
    cnt_rdata_q <= cnt_mem[s_axis_tdata[IW-1:0]];
    if (cnt_we) begin
      cnt_mem[idx_q] <= cnt_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_rdata_q <= ent_mem[ent_raddr];
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
    end else if (cnt_we) begin
      cnt_vld_q[idx_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q <= LW'(64);
    end else if (cfg_we_i) begin
      cfg_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= vsa_pkg::S_IDLE;
      cur_snap_q <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_snap_q <= cur_snap_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    idx_q      <= idx_d;
    val_q      <= val_d;
    qry_q      <= qry_d;
    cnt_q      <= cnt_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    res_val_q  <= res_val_d;
    res_snap_q <= res_snap_d;
    res_st_q   <= res_st_d;
    out_val_q  <= out_val_d;
    out_snap_q <= out_snap_d;
    out_st_q   <= out_st_d;
  end

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    idx_d      = idx_q;
    val_d      = val_q;
    qry_d      = qry_q;
    cnt_d      = cnt_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    mid_d      = mid_q;
    cur_snap_d = cur_snap_q;
    res_val_d  = res_val_q;
    res_snap_d = res_snap_q;
    res_st_d   = res_st_q;
    out_val_d  = out_val_q;
    out_snap_d = out_snap_q;
    out_st_d   = out_st_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    cnt_we     = 1'b0;
    cnt_wdata  = '0;
    ent_we     = 1'b0;
    ent_waddr  = '0;
    ent_wdata  = '{snap: cur_snap_q, val: val_q};
    ent_raddr  = '0;
    cnt_n      = cnt_vld_q[idx_q] ? cnt_rdata_q : '0;
    lo_n       = lo_q;
    hi_n       = hi_q;
    mid_sum    = '0;

    unique case (state_q)
      vsa_pkg::S_IDLE: begin
        if (s_acc) begin
          cmd_d   = vsa_pkg::cmd_e'(s_axis_tuser);
          idx_d   = s_axis_tdata[5:0];
          val_d   = s_axis_tdata[37:6];
          qry_d   = s_axis_tdata[53:38];
          state_d = vsa_pkg::S_DECODE;
        end
      end

      vsa_pkg::S_DECODE: begin
        res_val_d  = '0;
        res_snap_d = '0;
        res_st_d   = vsa_pkg::ST_OK;
        state_d    = vsa_pkg::S_DONE;
        cnt_d      = cnt_n;
        unique case (cmd_q)
          vsa_pkg::CMD_SNAP: begin
            res_snap_d = OW'(cur_snap_q);
            if (cur_snap_q == '1) begin
              res_st_d = vsa_pkg::ST_SAT;
            end else begin
              cur_snap_d = cur_snap_q + 1'b1;
            end
          end
          vsa_pkg::CMD_NOP: begin
          end
          vsa_pkg::CMD_SET, vsa_pkg::CMD_GET: begin
            if (out_of_range) begin
              res_st_d = vsa_pkg::ST_RANGE;
            end else if (cmd_q == vsa_pkg::CMD_SET) begin
              if (cnt_n == '0) begin
                ent_we    = 1'b1;
                ent_waddr = {idx_q, HW'(0)};
                cnt_we    = 1'b1;
                cnt_wdata = CW'(1);
              end else begin
                ent_raddr = {idx_q, HW'(cnt_n - 1'b1)};
                state_d   = vsa_pkg::S_SET_CHK;
              end
            end else if (cnt_n != '0) begin
              lo_d      = '0;
              hi_d      = cnt_n;
              mid_d     = cnt_n[HW:1];
              ent_raddr = {idx_q, cnt_n[HW:1]};
              state_d   = vsa_pkg::S_SEARCH;
            end
          end
          default: begin
          end
        endcase
      end

      vsa_pkg::S_SET_CHK: begin
        state_d = vsa_pkg::S_DONE;
        if (ent_rdata_q.snap == cur_snap_q) begin
          ent_we    = 1'b1;
          ent_waddr = {idx_q, HW'(cnt_q - 1'b1)};
        end else if (cnt_q == CW'(vsa_pkg::HISTORY_DEPTH)) begin
          res_st_d = vsa_pkg::ST_FULL;
        end else begin
          ent_we    = 1'b1;
          ent_waddr = {idx_q, cnt_q[HW-1:0]};
          cnt_we    = 1'b1;
          cnt_wdata = cnt_q + 1'b1;
        end
      end

      vsa_pkg::S_SEARCH: begin
        if (snap_le) begin
          lo_n      = CW'(mid_q) + 1'b1;
          res_val_d = ent_rdata_q.val;
        end else begin
          hi_n = CW'(mid_q);
        end
        lo_d    = lo_n;
        hi_d    = hi_n;
        mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
        mid_d   = mid_sum[HW:1];
        if (lo_n < hi_n) begin
          ent_raddr = {idx_q, mid_sum[HW:1]};
        end else begin
          state_d = vsa_pkg::S_DONE;
        end
      end

      vsa_pkg::S_DONE: begin
        if (out_free) begin
          out_val_d  = res_val_q;
          out_snap_d = res_snap_q;
          out_st_d   = res_st_q;
          m_valid_d  = 1'b1;
          state_d    = vsa_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = vsa_pkg::S_IDLE;
      end
    endcase
  end

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> state_q == vsa_pkg::S_DECODE)
    else $error("accepted beat did not enter decode");

  a_search_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == vsa_pkg::S_SEARCH |->
      lo_q < hi_q && hi_q <= CW'(vsa_pkg::HISTORY_DEPTH))
    else $error("search window out of bounds");

  a_snap_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (cur_snap_q == $past(cur_snap_q) || cur_snap_q == $past(cur_snap_q) + 1'b1))
    else $error("snapshot counter jumped");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q) == vsa_pkg::S_DONE)
    else $error("result raised outside done");

endmodule

@@ tb/tb_versioned_snapshot_array.sv @@
`timescale 1ns / 1ps

module tb_versioned_snapshot_array;
  import vsa_pkg::*;

  typedef struct {
    logic signed [VAL_W-1:0] read_value;
    logic [OSN_W-1:0]        snap_number;
    status_e                 status;
  } access_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [6:0]  cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  // shadow copy of the array contents and the length register
  logic [CFG_W-1:0]        length_reg;
  logic [SNAP_BITS-1:0]    snap_now;
  int                      hist_len  [MAX_INDICES];
  logic [SNAP_BITS-1:0]    hist_snap [MAX_INDICES][HISTORY_DEPTH];
  logic signed [VAL_W-1:0] hist_val  [MAX_INDICES][HISTORY_DEPTH];

  access_result_t pending_results[$];
  int             send_idle_pct  = 0;
  int             recv_stall_pct = 0;
  int             hold_cycles    = 0;
  int             failures       = 0;
  int             beats_sent     = 0;
  int             results_checked = 0;
  int             full_seen      = 0;
  int             range_seen     = 0;
  int             sat_seen       = 0;

  versioned_snapshot_array dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic access_result_t apply_command(cmd_e c, logic [IDX_W-1:0] idx,
                                                   logic signed [VAL_W-1:0] v,
                                                   logic [SNAP_BITS-1:0] q);
    access_result_t r;
    int n;
    int eff;
    bit found;
    r.read_value  = '0;
    r.snap_number = '0;
    r.status      = ST_OK;
    found = 1'b0;
    eff = (int'(length_reg) < MAX_INDICES) ? int'(length_reg) : MAX_INDICES;
    if (c == CMD_SNAP) begin
      r.snap_number = snap_now;
      if (snap_now == '1) r.status = ST_SAT;
      else snap_now = snap_now + 1'b1;
    end else if (c != CMD_NOP) begin
      if (int'(idx) >= eff) begin
        r.status = ST_RANGE;
      end else begin
        n = hist_len[idx];
        if (c == CMD_SET) begin
          if (n > 0 && hist_snap[idx][n-1] == snap_now) begin
            hist_val[idx][n-1] = v;
          end else if (n >= HISTORY_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            hist_snap[idx][n] = snap_now;
            hist_val[idx][n]  = v;
            hist_len[idx]     = n + 1;
          end
        end else begin
          for (int k = n - 1; k >= 0; k--) begin
            if (!found && hist_snap[idx][k] <= q) begin
              r.read_value = hist_val[idx][k];
              found = 1'b1;
            end
          end
        end
      end
    end
    return r;
  endfunction

  task automatic send_beat(cmd_e c, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] v,
                           logic [SNAP_BITS-1:0] q);
    access_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, q, v, idx};
    s_axis_tuser  <= c;
    do @(posedge clk_i); while (!s_axis_tready);
    r = apply_command(c, idx, v, q);
    if (r.status == ST_FULL) full_seen++;
    if (r.status == ST_RANGE) range_seen++;
    if (r.status == ST_SAT) sat_seen++;
    pending_results = {pending_results, r};
    beats_sent++;
  endtask

  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_length(logic [CFG_W-1:0] len);
    wait_results_done();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    length_reg = len;
  endtask

  // result checker and receiver stall generator
  always @(posedge clk_i) begin
    access_result_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: tdata %h tuser %0d", m_axis_tdata,
               m_axis_tuser);
        failures++;
      end else begin
        e = pending_results.pop_front();
        results_checked++;
        if (m_axis_tdata[31:0] !== e.read_value) begin
          $error("read_value: expected %0d, got %0d", e.read_value,
                 $signed(m_axis_tdata[31:0]));
          failures++;
        end
        if (m_axis_tdata[47:32] !== e.snap_number) begin
          $error("snap_number: expected %0d, got %0d", e.snap_number, m_axis_tdata[47:32]);
          failures++;
        end
        if (m_axis_tuser !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, m_axis_tuser);
          failures++;
        end
      end
    end
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles   <= hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(5) != 0) return $urandom();
    case ($urandom_range(3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  task automatic test_directed();
    write_length(7'd64);
    send_beat(CMD_GET, 6'd0, 32'h0, 16'd0);
    send_beat(CMD_SET, 6'd0, 32'h7fff_ffff, 16'd0);
    send_beat(CMD_SET, 6'd0, 32'h8000_0000, 16'd0);
    send_beat(CMD_GET, 6'd0, 32'h0, 16'd0);
    send_beat(CMD_SNAP, 6'd0, 32'h0, 16'd0);
    send_beat(CMD_SET, 6'd63, 32'hffff_ffff, 16'hffff);
    send_beat(CMD_GET, 6'd63, 32'h0, 16'hffff);
    send_beat(CMD_GET, 6'd63, 32'hffff_ffff, 16'd0);
    send_beat(CMD_SET, 6'd0, 32'd12345, 16'd0);
    send_beat(CMD_GET, 6'd0, 32'h0, 16'd0);
    send_beat(CMD_GET, 6'd0, 32'h0, 16'd1);
    send_beat(CMD_GET, 6'd0, 32'h0, 16'd2);
    send_beat(CMD_NOP, 6'd63, 32'hffff_ffff, 16'hffff);
    send_beat(CMD_NOP, 6'd0, 32'h0, 16'd0);
    send_beat(CMD_SNAP, 6'd63, 32'hffff_ffff, 16'hffff);
    send_beat(CMD_GET, 6'd1, 32'h0, 16'd5);
    send_beat(CMD_SET, 6'd42, 32'h5555_aaaa, 16'h0);
    send_beat(CMD_GET, 6'd42, 32'h0, 16'h5555);
    send_beat(CMD_GET, 6'd42, 32'h0, 16'haaaa);
  endtask

  task automatic test_history_full();
    logic [SNAP_BITS-1:0] first_snap;
    first_snap = snap_now;
    for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
      send_beat(CMD_SET, 6'd7, 32'(i * 1000 - 7000), 16'd0);
      send_beat(CMD_SNAP, 6'd0, 32'h0, 16'd0);
    end
    send_beat(CMD_SET, 6'd7, 32'h1234_5678, 16'd0);
    // newest entry is rewritten in place even with the history full
    send_beat(CMD_SET, 6'd7, 32'h8765_4321, 16'd0);
    send_beat(CMD_SNAP, 6'd0, 32'h0, 16'd0);
    send_beat(CMD_SET, 6'd7, 32'h0bad_0bad, 16'd0);
    send_beat(CMD_SET, 6'd7, 32'h0bad_0bad, 16'd0);
    send_beat(CMD_GET, 6'd7, 32'h0, first_snap - 1'b1);
    send_beat(CMD_GET, 6'd7, 32'h0, first_snap);
    send_beat(CMD_GET, 6'd7, 32'h0, first_snap + 16'd7);
    send_beat(CMD_GET, 6'd7, 32'h0, snap_now);
    send_beat(CMD_GET, 6'd7, 32'h0, 16'hffff);
  endtask

  task automatic test_index_range();
    write_length(7'd1);
    send_beat(CMD_SET, 6'd0, 32'h0000_0055, 16'd0);
    send_beat(CMD_SET, 6'd1, 32'h0000_0066, 16'd0);
    send_beat(CMD_GET, 6'd63, 32'h0, 16'hffff);
    send_beat(CMD_GET, 6'd0, 32'h0, 16'hffff);
    write_length(7'd33);
    send_beat(CMD_SET, 6'd32, 32'h0000_0077, 16'd0);
    send_beat(CMD_SET, 6'd33, 32'h0000_0088, 16'd0);
    send_beat(CMD_GET, 6'd33, 32'h0, 16'hffff);
    send_beat(CMD_GET, 6'd32, 32'h0, 16'hffff);
    write_length(7'd64);
    send_beat(CMD_GET, 6'd63, 32'h0, 16'hffff);
  endtask

  task automatic send_random_item(logic [IDX_W-1:0] focus);
    int roll;
    logic [IDX_W-1:0] idx;
    logic [SNAP_BITS-1:0] q;
    roll = $urandom_range(99);
    idx  = focus + IDX_W'($urandom_range(3));
    if ($urandom_range(9) == 0) q = $urandom();
    else q = SNAP_BITS'($urandom_range(int'(snap_now) + 1));
    if (roll < 40) send_beat(CMD_SET, idx, pick_value(), q);
    else if (roll < 55) send_beat(CMD_SNAP, idx, pick_value(), q);
    else if (roll < 92) send_beat(CMD_GET, idx, pick_value(), q);
    else if (roll < 96) send_beat(CMD_NOP, IDX_W'($urandom()), pick_value(), q);
    else send_beat(($urandom_range(1) == 0) ? CMD_SET : CMD_GET, IDX_W'($urandom()),
                   pick_value(), q);
  endtask

  task automatic test_random_traffic(int count, int idle_pct, int stall_pct,
                                     logic [CFG_W-1:0] len);
    logic [IDX_W-1:0] focus;
    write_length(len);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    focus = '0;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) focus = IDX_W'($urandom_range(int'(len) - 1));
      send_random_item(focus);
    end
    wait_results_done();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    wait_results_done();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles <= 300;
    for (int i = 0; i < 40; i++) send_random_item(6'd20);
    // sender waits here until the array has answered everything
    wait_results_done();
  endtask

  task automatic test_snap_run();
    write_length(7'd64);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_beat(CMD_SET, 6'd5, 32'h0000_0005, 16'd0);
    repeat (24) send_beat(CMD_SNAP, 6'd0, 32'h0, 16'd0);
    send_beat(CMD_SET, 6'd5, 32'h7fff_0005, 16'd0);
    send_beat(CMD_SNAP, 6'd0, 32'h0, 16'd0);
    send_beat(CMD_SNAP, 6'd63, 32'hffff_ffff, 16'hffff);
    send_beat(CMD_SET, 6'd5, 32'h8000_0005, 16'd0);
    send_beat(CMD_GET, 6'd5, 32'h0, 16'hffff);
    send_beat(CMD_GET, 6'd5, 32'h0, 16'hfffe);
    send_beat(CMD_GET, 6'd5, 32'h0, 16'd0);
    for (int i = 0; i < 60; i++) send_random_item(6'd4);
    wait_results_done();
  endtask

  initial begin
    length_reg = 7'd64;
    snap_now   = '0;
    for (int i = 0; i < MAX_INDICES; i++) hist_len[i] = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_history_full();
    test_index_range();
    test_backpressure();
    test_random_traffic(260, 0, 0, 7'd64);
    test_random_traffic(260, 78, 0, 7'd40);
    test_random_traffic(260, 0, 78, 7'd64);
    test_random_traffic(260, 36, 36, 7'd17);
    test_snap_run();

    wait_results_done();
    repeat (20) @(posedge clk_i);
    $display("sent %0d beats, checked %0d results: sets, snaps, gets and no-ops",
             beats_sent, results_checked);
    $display("history full %0d, index out of range %0d, counter saturated %0d times",
             full_seen, range_seen, sat_seen);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("tb_versioned_snapshot_array OK");
    end else begin
      $display("tb_versioned_snapshot_array NOT OK");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("tb_versioned_snapshot_array NOT OK");
    $finish;
  end

endmodule
